// File: hdl/lpm_pkg.sv
// Shared types, constants and helpers for the lidar packet to polar map block.
// Used by the controller, the datapath, the top level and the checker. No dependencies.
`timescale 1ns / 1ps

package lpm_pkg;

	localparam int BYTE_W = 8;
	localparam int DIST_W = 14;
	localparam int BIN_W = 9;
	localparam int CFG_IDX_W = 1;
	localparam int OUT_TDATA_W = 32;

	localparam int WIN_DEPTH = 5;
	localparam logic [2:0] WIN_FULL = 3'd5;

	localparam int MAP_SIZE = 360;
	localparam logic [BIN_W-1:0] MAP_LAST = 9'(MAP_SIZE - 1);
	localparam logic [9:0] BIN_OFFSET = 10'd180;

	localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h3E;
	localparam logic [DIST_W-1:0] MIN_VALID_DISTANCE = 14'd100;
	localparam logic [DIST_W-1:0] LIMIT_RESET = 14'd16383;

	localparam logic [CFG_IDX_W-1:0] REG_DIST_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_MODE = 1'd1;

	localparam logic [2:0] RES_NONE = 3'd0;
	localparam logic [2:0] RES_LIMIT = 3'd1;
	localparam logic [2:0] RES_DIST = 3'd2;
	localparam logic [2:0] RES_FILL = 3'd3;
	localparam logic [2:0] RES_KEEP = 3'd4;
	localparam logic [2:0] RES_FAIL = 3'd5;

	typedef struct packed {
		logic       shift;
		logic       clear_we;
		logic       capture;
		logic       search_start;
		logic       search_step;
		logic [2:0] res_op;
		logic       out_load;
	} lpm_cmd_t;

	typedef struct packed {
		logic hit;
		logic ge_limit;
		logic lt_min;
		logic fill_mode;
		logic rd_ok;
		logic search_last;
		logic clear_last;
	} lpm_status_t;

	function automatic logic [BIN_W-1:0] prev_bin(input logic [BIN_W-1:0] a);
		logic [BIN_W-1:0] r;
		if (a == '0) begin
			r = MAP_LAST;
		end else begin
			r = a - 9'd1;
		end
		return r;
	endfunction

endpackage

// File: hdl/lidar_packet_to_polar_map.sv
// Top level of the lidar packet to polar map block.
// Depends on lpm_pkg, lpm_ctrl and lpm_datapath.
//
// Channel  Direction  Handshake            Payload
// s_*      in         s_tvalid / s_tready  rx_byte
// m_*      out        m_tvalid / m_tready  bin, stored_value, written, filled, fill_failed
// cfg_*    in         cfg_we               distance_limit (0), fill_mode (1)
//
// A byte that completes no packet passes the check state and returns to idle. A decoded packet
// passes the check, decide and output states; when needed, a backward fill search runs between
// decide and output and reads one map entry per cycle through the single read port of the map
// memory. While the map is cleared after reset, no byte is accepted.
// A finished result waits in the output register while the next bytes are taken;
// a second result waits for it to leave.
`timescale 1ns / 1ps

module lidar_packet_to_polar_map
	import lpm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,  // [7:0] rx_byte
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // [8:0] bin, [22:9] stored_value, [23] written,
	                                         // [24] filled, [25] fill_failed, [31:26] zero
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [DIST_W-1:0]      cfg_data
);

	lpm_cmd_t    cmd;
	lpm_status_t status;

	lpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lpm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_tdata (m_tdata)
	);

endmodule

// File: hdl/lpm_ctrl.sv
// Controller state machine for the lidar packet to polar map block.
// Depends on lpm_pkg; drives the datapath commands and both handshakes.
`timescale 1ns / 1ps

module lpm_ctrl
	import lpm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  lpm_status_t status,
	output lpm_cmd_t    cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_SEARCH = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       m_tvalid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.res_op = RES_NONE;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_we = 1'b1;
				if (status.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.shift = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.capture = 1'b1;
				state_d = status.hit ? ST_DECIDE : ST_IDLE;
			end
			ST_DECIDE: begin
				state_d = ST_OUT;
				if (status.ge_limit) begin
					cmd.res_op = RES_LIMIT;
				end else if (status.lt_min) begin
					if (!status.fill_mode) begin
						cmd.res_op = RES_KEEP;
					end else if (status.rd_ok) begin
						cmd.res_op = RES_FILL;
					end else begin
						cmd.search_start = 1'b1;
						state_d = ST_SEARCH;
					end
				end else begin
					cmd.res_op = RES_DIST;
				end
			end
			ST_SEARCH: begin
				if (status.rd_ok) begin
					cmd.res_op = RES_FILL;
					state_d = ST_OUT;
				end else if (status.search_last) begin
					cmd.res_op = RES_FAIL;
					state_d = ST_OUT;
				end else begin
					cmd.search_step = 1'b1;
				end
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hdl/lpm_datapath.sv
// Datapath of the lidar packet to polar map block: byte window, decode,
// configuration registers, the polar map memory, search and result registers.
// Depends on lpm_pkg; steered by lpm_ctrl.
`timescale 1ns / 1ps

module lpm_datapath
	import lpm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [BYTE_W-1:0]      rx_byte,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [DIST_W-1:0]      cfg_data,
	input  lpm_cmd_t               cmd,
	output lpm_status_t            status,
	output logic [OUT_TDATA_W-1:0] out_tdata
);

	logic [BYTE_W-1:0] win_q [WIN_DEPTH];
	logic [2:0]        win_cnt_q;
	logic [DIST_W-1:0] limit_q;
	logic              fill_q;
	logic [BIN_W-1:0]  clr_cnt_q;
	logic [BIN_W-1:0]  bin_q;
	logic [DIST_W-1:0] dist_q;
	logic [BIN_W-1:0]  idx_q;
	logic [BIN_W-1:0]  search_cnt_q;
	logic [DIST_W-1:0] first_q;
	logic [DIST_W-1:0] res_val_q;
	logic              res_written_q;
	logic              res_filled_q;
	logic              res_failed_q;
	logic [BIN_W-1:0]  out_bin_q;
	logic [DIST_W-1:0] out_val_q;
	logic              out_written_q;
	logic              out_filled_q;
	logic              out_failed_q;

	logic [DIST_W-1:0] map_mem [MAP_SIZE];
	logic [DIST_W-1:0] rdata_q;

	logic [9:0]        bin_sum;
	logic [BIN_W-1:0]  bin_c;
	logic [DIST_W-1:0] dist_c;
	logic [BIN_W-1:0]  rd_addr;
	logic              map_we;
	logic [BIN_W-1:0]  map_waddr;
	logic [DIST_W-1:0] map_wdata;
	logic [DIST_W-1:0] res_val_d;

	// The angle word divided by 128 reduces to the second payload byte and
	// the top bit of the first one; the sum stays below twice the map size.
	assign bin_sum = BIN_OFFSET + {1'b0, win_q[2], win_q[1][7]};
	assign bin_c = (bin_sum >= 10'(MAP_SIZE)) ? 9'(bin_sum - 10'(MAP_SIZE)) : bin_sum[8:0];
	assign dist_c = {win_q[4], win_q[3][7:2]};

	assign status.hit = (win_cnt_q == WIN_FULL) && (win_q[0] == SYNC_BYTE);
	assign status.ge_limit = (dist_q >= limit_q);
	assign status.lt_min = (dist_q < MIN_VALID_DISTANCE);
	assign status.fill_mode = fill_q;
	assign status.rd_ok = (rdata_q >= MIN_VALID_DISTANCE);
	assign status.search_last = (search_cnt_q == MAP_LAST);
	assign status.clear_last = (clr_cnt_q == MAP_LAST);

	always_comb begin
		if (cmd.search_start) begin
			rd_addr = prev_bin(bin_q);
		end else if (cmd.search_step) begin
			rd_addr = prev_bin(idx_q);
		end else begin
			rd_addr = bin_c;
		end
	end

	always_comb begin
		case (cmd.res_op)
			RES_LIMIT: res_val_d = limit_q;
			RES_DIST:  res_val_d = dist_q;
			RES_FILL:  res_val_d = rdata_q;
			RES_KEEP:  res_val_d = rdata_q;
			RES_FAIL:  res_val_d = first_q;
			default:   res_val_d = rdata_q;
		endcase
	end

	always_comb begin
		map_we = 1'b0;
		map_waddr = bin_q;
		map_wdata = res_val_d;
		if (cmd.clear_we) begin
			map_we = 1'b1;
			map_waddr = clr_cnt_q;
			map_wdata = '0;
		end else if (cmd.res_op inside {RES_LIMIT, RES_DIST, RES_FILL}) begin
			map_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
		rdata_q <= map_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WIN_DEPTH; k++) begin
				win_q[k] <= '0;
			end
			win_cnt_q <= '0;
			limit_q <= LIMIT_RESET;
			fill_q <= 1'b0;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.shift) begin
				for (int k = 0; k < WIN_DEPTH - 1; k++) begin
					win_q[k] <= win_q[k+1];
				end
				win_q[WIN_DEPTH-1] <= rx_byte;
				if (win_cnt_q != WIN_FULL) begin
					win_cnt_q <= win_cnt_q + 3'd1;
				end
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DIST_LIMIT: limit_q <= cfg_data;
					REG_FILL_MODE:  fill_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.clear_we) begin
				clr_cnt_q <= clr_cnt_q + 9'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			bin_q <= bin_c;
			dist_q <= dist_c;
		end
		if (cmd.search_start) begin
			idx_q <= prev_bin(bin_q);
			search_cnt_q <= 9'd1;
			first_q <= rdata_q;
		end else if (cmd.search_step) begin
			idx_q <= prev_bin(idx_q);
			search_cnt_q <= search_cnt_q + 9'd1;
		end
		if (cmd.res_op != RES_NONE) begin
			res_val_q <= res_val_d;
			res_written_q <= (cmd.res_op == RES_LIMIT) || (cmd.res_op == RES_DIST) ||
				(cmd.res_op == RES_FILL);
			res_filled_q <= (cmd.res_op == RES_FILL);
			res_failed_q <= (cmd.res_op == RES_FAIL);
		end
		if (cmd.out_load) begin
			out_bin_q <= bin_q;
			out_val_q <= res_val_q;
			out_written_q <= res_written_q;
			out_filled_q <= res_filled_q;
			out_failed_q <= res_failed_q;
		end
	end

	assign out_tdata = {6'd0, out_failed_q, out_filled_q, out_written_q, out_val_q, out_bin_q};

endmodule

// File: hdl/lpm_checker.sv
// Port-level checks for the lidar packet to polar map block, bound to the top level.
// Depends on lpm_pkg and lidar_packet_to_polar_map.
`timescale 1ns / 1ps

module lpm_checker
	import lpm_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Result transaction dropped while stalled.");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("Result payload changed while stalled.");

	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[8:0] < 9'(MAP_SIZE)))
		else $error("Result bin outside the map.");

	a_filled_written: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[24] |-> m_tdata[23] && !m_tdata[25])
		else $error("Filled result not marked as written.");

	a_failed_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[25] |-> !m_tdata[23] && (m_tdata[22:9] < MIN_VALID_DISTANCE))
		else $error("Failed fill search reported a usable value.");

endmodule

bind lidar_packet_to_polar_map lpm_checker u_lpm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
